/* rtl/taq_pkg.sv */
// Package with types, register indexes and codes for the threshold alarm qualifier.
`default_nettype none

package taq_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 40;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RULE_ENABLED       = 3'd0;
    localparam logic [2:0] REG_COMPARE_MODE       = 3'd1;
    localparam logic [2:0] REG_THRESHOLD          = 3'd2;
    localparam logic [2:0] REG_HYSTERESIS         = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME_MS       = 3'd4;
    localparam logic [2:0] REG_FIRE_GAP_MS        = 3'd5;
    localparam logic [2:0] REG_INTERLOCK_ENABLE   = 3'd6;
    localparam logic [2:0] REG_INTERLOCK_REQUIRED = 3'd7;

    // compare modes
    localparam logic [2:0] MODE_GT = 3'd0;
    localparam logic [2:0] MODE_GE = 3'd1;
    localparam logic [2:0] MODE_LT = 3'd2;
    localparam logic [2:0] MODE_LE = 3'd3;
    localparam logic [2:0] MODE_EQ = 3'd4;
    localparam logic [2:0] MODE_NE = 3'd5;

    // outcome codes
    localparam logic [2:0] OUT_SKIP    = 3'd0;
    localparam logic [2:0] OUT_NOMATCH = 3'd1;
    localparam logic [2:0] OUT_WAIT    = 3'd2;
    localparam logic [2:0] OUT_BLOCKED = 3'd3;
    localparam logic [2:0] OUT_FIRE    = 3'd4;

    localparam logic [31:0] COOLDOWN_DEFAULT = 32'd1000;
    localparam logic signed [33:0] EQ_BAND_MIN = 34'sd7;

    typedef struct packed {
        logic               rule_enabled;
        logic [2:0]         compare_mode;
        logic signed [31:0] threshold;
        logic signed [31:0] hysteresis;
        logic [31:0]        hold_time_ms;
        logic [31:0]        fire_gap_ms;
        logic               interlock_enable;
        logic               interlock_required;
    } taq_cfg_t;

    typedef struct packed {
        logic               interlock_quality_good;
        logic               interlock_on;
        logic               interlock_valid;
        logic               source_valid;
        logic [47:0]        time_ms;
        logic signed [31:0] sample_value;
    } taq_item_t;

    typedef struct packed {
        logic [31:0] evaluation_count;
        logic        condition_met;
        logic [2:0]  outcome;
    } taq_result_t;

endpackage

`default_nettype wire

/* rtl/threshold_alarm_qualifier_core.sv */
// Top level of the threshold alarm qualifier: input register, qualifier, result register.
//
// One request is accepted every clock cycle while the master side does not stall; it passes
// the input register and then the result register: the compare, hold, cooldown and interlock
// checks run combinationally on the registered request against the rule state and land in
// the result register. The rule state advances as each evaluated request moves into the
// result register, so requests are qualified strictly in order. A stalled master side holds
// the result register; the input register still takes one more request behind it.
// Configuration goes through the APB port at byte address 4*index and should be
// written only while no request is in flight.
`default_nettype none

module threshold_alarm_qualifier_core
    import taq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave: sample_value[31:0], time_ms[79:32], source_valid[80], interlock_valid[81],
    //        interlock_on[82], interlock_quality_good[83], zero[87:84]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // master: outcome[2:0], condition_met[3], evaluation_count[35:4], zero[39:36]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    taq_cfg_t    cfg;
    taq_item_t   in_item_reg;
    logic        in_valid_reg;
    taq_result_t result;
    taq_result_t out_data_reg;
    logic        out_valid_reg;
    logic        advance;

    taq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    taq_qualify u_qualify (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_tdata[$bits(taq_item_t)-1:0];
        if (advance)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire

/* rtl/taq_regs.sv */
// APB configuration registers of the threshold alarm qualifier.
`default_nettype none

module taq_regs
    import taq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output taq_cfg_t                   cfg
);

    taq_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rule_enabled       <= 1'b0;
            cfg_reg.compare_mode       <= MODE_GT;
            cfg_reg.threshold          <= '0;
            cfg_reg.hysteresis         <= '0;
            cfg_reg.hold_time_ms       <= '0;
            cfg_reg.fire_gap_ms        <= COOLDOWN_DEFAULT;
            cfg_reg.interlock_enable   <= 1'b0;
            cfg_reg.interlock_required <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RULE_ENABLED:       cfg_reg.rule_enabled       <= pwdata[0];
                REG_COMPARE_MODE:       cfg_reg.compare_mode       <= pwdata[2:0];
                REG_THRESHOLD:          cfg_reg.threshold          <= $signed(pwdata);
                REG_HYSTERESIS:         cfg_reg.hysteresis         <= $signed(pwdata);
                REG_HOLD_TIME_MS:       cfg_reg.hold_time_ms       <= pwdata;
                REG_FIRE_GAP_MS:        cfg_reg.fire_gap_ms        <= pwdata;
                REG_INTERLOCK_ENABLE:   cfg_reg.interlock_enable   <= pwdata[0];
                REG_INTERLOCK_REQUIRED: cfg_reg.interlock_required <= pwdata[0];
                default:                cfg_reg.rule_enabled       <= cfg_reg.rule_enabled;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RULE_ENABLED:       prdata = {31'b0, cfg_reg.rule_enabled};
            REG_COMPARE_MODE:       prdata = {29'b0, cfg_reg.compare_mode};
            REG_THRESHOLD:          prdata = cfg_reg.threshold;
            REG_HYSTERESIS:         prdata = cfg_reg.hysteresis;
            REG_HOLD_TIME_MS:       prdata = cfg_reg.hold_time_ms;
            REG_FIRE_GAP_MS:        prdata = cfg_reg.fire_gap_ms;
            REG_INTERLOCK_ENABLE:   prdata = {31'b0, cfg_reg.interlock_enable};
            REG_INTERLOCK_REQUIRED: prdata = {31'b0, cfg_reg.interlock_required};
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/taq_compare.sv */
// Sample versus threshold compare with hysteresis and equality band.
`default_nettype none

module taq_compare
    import taq_pkg::*;
(
    input  taq_cfg_t                 cfg,
    input  wire logic signed [31:0]  sample_value,
    input  wire logic                prev_active,
    output logic                     match
);

    logic signed [33:0] val;
    logic signed [33:0] thr;
    logic signed [33:0] hy;
    logic signed [33:0] hpos;
    logic signed [33:0] band;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] diff;
    logic signed [33:0] adiff;

    assign val  = 34'(sample_value);
    assign thr  = 34'(cfg.threshold);
    assign hy   = 34'(cfg.hysteresis);
    assign hpos = hy[33] ? '0 : hy;
    assign band = (hy > EQ_BAND_MIN) ? hy : EQ_BAND_MIN;
    // widen toward the inactive side only while the condition holds
    assign lo   = prev_active ? (thr - hpos) : thr;
    assign hi   = prev_active ? (thr + hpos) : thr;
    assign diff  = val - thr;
    assign adiff = diff[33] ? -diff : diff;

    always_comb
    begin
        case (cfg.compare_mode)
            MODE_GT: match = val > lo;
            MODE_GE: match = val >= lo;
            MODE_LT: match = val < hi;
            MODE_LE: match = val <= hi;
            MODE_EQ: match = adiff <= band;
            MODE_NE: match = adiff > band;
            default: match = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/taq_qualify.sv */
// Hold, cooldown and interlock qualification with the rule state registers.
`default_nettype none

module taq_qualify
    import taq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  taq_cfg_t   cfg,
    input  taq_item_t  item,
    output taq_result_t result
);

    logic        cond_active_reg;
    logic        since_set_reg;
    logic [47:0] match_since_reg;
    logic [47:0] last_fire_reg;
    logic [31:0] evals_reg;

    logic        run;
    logic        match;
    logic [47:0] since_start;
    logic [47:0] hold_span;
    logic [47:0] cd_span;
    logic        hold_ok;
    logic        cd_ok;
    logic        allow;
    logic        fire_slot;
    logic [31:0] evals_next;

    taq_compare u_compare (
        .cfg          (cfg),
        .sample_value (item.sample_value),
        .prev_active  (cond_active_reg),
        .match        (match)
    );

    assign run         = cfg.rule_enabled & item.source_valid;
    assign since_start = since_set_reg ? match_since_reg : item.time_ms;
    assign hold_span   = {16'b0, cfg.hold_time_ms};
    assign cd_span     = {16'b0, (cfg.fire_gap_ms == '0) ? COOLDOWN_DEFAULT : cfg.fire_gap_ms};
    // time going back counts as not elapsed
    assign hold_ok     = (item.time_ms >= since_start) &&
                         ((item.time_ms - since_start) >= hold_span);
    assign cd_ok       = (item.time_ms >= last_fire_reg) &&
                         ((item.time_ms - last_fire_reg) >= cd_span);
    assign allow       = !cfg.interlock_enable ||
                         (item.interlock_valid && item.interlock_quality_good &&
                          (item.interlock_on == cfg.interlock_required));
    assign fire_slot   = match & hold_ok & cd_ok;
    assign evals_next  = run ? (evals_reg + 32'd1) : evals_reg;

    always_comb
    begin
        result.evaluation_count = evals_next;
        result.condition_met    = run & match;
        if (!run)
            result.outcome = OUT_SKIP;
        else if (!match)
            result.outcome = OUT_NOMATCH;
        else if (!fire_slot)
            result.outcome = OUT_WAIT;
        else if (allow)
            result.outcome = OUT_FIRE;
        else
            result.outcome = OUT_BLOCKED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_active_reg <= 1'b0;
            since_set_reg   <= 1'b0;
            match_since_reg <= '0;
            last_fire_reg   <= '0;
            evals_reg       <= '0;
        end
        else if (advance && run)
        begin
            evals_reg       <= evals_next;
            cond_active_reg <= match;
            if (!match)
            begin
                since_set_reg   <= 1'b0;
                match_since_reg <= '0;
            end
            else
            begin
                since_set_reg   <= 1'b1;
                match_since_reg <= since_start;
                // a blocked interlock still restarts the cooldown
                if (fire_slot)
                    last_fire_reg <= item.time_ms;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/taq_checker.sv */
// Port-level checker for the threshold alarm qualifier and its bind.
`default_nettype none

module taq_checker
    import taq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic [31:0] last_cnt_reg;
    logic        seen_reg;
    logic        out_acc;
    logic [2:0]  outcome;
    logic        cond_met;
    logic [31:0] cnt;

    assign out_acc  = m_tvalid & m_tready;
    assign outcome  = m_tdata[2:0];
    assign cond_met = m_tdata[3];
    assign cnt      = m_tdata[35:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_cnt_reg <= '0;
        end
        else if (out_acc)
        begin
            seen_reg     <= 1'b1;
            last_cnt_reg <= cnt;
        end
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // skip and no-match never report a met condition; the others always do
    a_cond_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cond_met == ((outcome == OUT_WAIT) || (outcome == OUT_BLOCKED) ||
                                   (outcome == OUT_FIRE))))
        else $error("condition_met disagrees with outcome");

    // count advances by one per evaluated request and stays on a skip
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg |->
            ((outcome == OUT_SKIP) ? (cnt == last_cnt_reg) : (cnt == last_cnt_reg + 32'd1)))
        else $error("evaluation count stepped wrongly");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind threshold_alarm_qualifier_core taq_checker u_taq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
